// ===== hw/rtl/pose_error_velocity_control_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the pose error velocity control core
// Shared forms for concurrent checks, clocked on a rising edge.
// ---------------------------------------------------------------------------
`ifndef POSE_ERROR_VELOCITY_CONTROL_CORE_MACROS_SVH
`define POSE_ERROR_VELOCITY_CONTROL_CORE_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define PEVC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pevc check failed");

// Next-cycle implication, switched off while reset is high.
`define PEVC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pevc check failed");

`endif

// ===== hw/rtl/pevc_pkg.sv =====
// ---------------------------------------------------------------------------
// pevc_pkg
// Types, constants and helper functions of the pose error velocity core.
// ---------------------------------------------------------------------------
package pevc_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CORDIC_MAX  = 24;

   // Register indexes of the configuration port.
   localparam logic [1:0] REG_GAIN_X       = 2'd0;
   localparam logic [1:0] REG_GAIN_Y       = 2'd1;
   localparam logic [1:0] REG_GAIN_HEADING = 2'd2;

   localparam logic [15:0] GAIN_RESET = 16'd256;

   // CORDIC start value: the reciprocal of the gain limit in Q2.30.
   localparam logic signed [33:0] CORDIC_K = 34'sd652032874;

   // Two pi in Q3.29.
   localparam logic [32:0] TWO_PI_Q29 = 33'd3373259426;

   // Arctangent of 2^-i in units of 2^-32 turn.
   localparam logic [31:0] ATAN_TURNS [CORDIC_MAX] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85005780,
      32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   // One classified word as it waits in the queue.
   typedef struct packed {
      logic signed [32:0] err_x;
      logic signed [32:0] err_y;
      logic signed [15:0] err_heading;
      logic signed [32:0] angle;
      logic               flip;
   } entry_type;

   // Gain registers as seen by the back end.
   typedef struct packed {
      logic [15:0] gain_x;
      logic [15:0] gain_y;
      logic [15:0] gain_heading;
   } gains_type;

   function automatic logic signed [32:0] atan_turn(input logic [4:0] idx);
      logic signed [32:0] res;
      res = $signed({1'b0, ATAN_TURNS[idx]});
      return res;
   endfunction

   // Saturate a scaled command to the signed 32-bit range.
   function automatic logic [31:0] sat32(input logic signed [44:0] v);
      logic [31:0] res;
      if (v > 45'sd2147483647) begin
         res = 32'h7fff_ffff;
      end else if (v < -45'sd2147483648) begin
         res = 32'h8000_0000;
      end else begin
         res = v[31:0];
      end
      return res;
   endfunction

endpackage

// ===== hw/rtl/pose_error_velocity_control_core.sv =====
// ---------------------------------------------------------------------------
// pose_error_velocity_control_core
// Holonomic pose-error controller: robot-frame velocity and turn commands.
// ---------------------------------------------------------------------------
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | req_tdata, 160 bit pose word
//  rsp     | out | rsp_tvalid/rsp_tready | rsp_tdata, 96 bit command word
//  csr     | in  | csr_valid/csr_ready   | csr_addr index, csr_wdata gain
//
// One word per cycle is sustained while rsp_tready keeps the output free; a
// pose word passes the queue, the CORDIC pipeline (one stage per iteration),
// the product, rotation and gain stages and the output register.
// Reset clears the queue, the valid chain and sets all gains to 1.0.
// A stalled output holds the back end; the front keeps filling a four word
// queue and drops req_tready only when that queue is full.
module pose_error_velocity_control_core #(
   parameter int TRIG_STAGES = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // cur_x, cur_y, cur_heading, goal_x, goal_y, goal_heading
   input  logic [159:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // vel_forward, vel_lateral, turn_rate
   output logic [95:0]  rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_addr,
   input  logic [15:0]  csr_wdata
);

   pevc_pkg::gains_type gains_ff;
   pevc_pkg::entry_type front_entry, q_data;
   logic                q_full, q_not_empty, q_pop, push;

   assign csr_ready  = 1'b1;
   assign req_tready = !q_full;
   assign push       = req_tvalid && !q_full;

   // Gain registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.gain_x       <= pevc_pkg::GAIN_RESET;
         gains_ff.gain_y       <= pevc_pkg::GAIN_RESET;
         gains_ff.gain_heading <= pevc_pkg::GAIN_RESET;
      end else if (csr_valid) begin
         unique case (csr_addr)
            pevc_pkg::REG_GAIN_X:       gains_ff.gain_x       <= csr_wdata;
            pevc_pkg::REG_GAIN_Y:       gains_ff.gain_y       <= csr_wdata;
            pevc_pkg::REG_GAIN_HEADING: gains_ff.gain_heading <= csr_wdata;
            default: ;
         endcase
      end
   end

   pevc_front u_front (
      .pose (req_tdata),
      .entry(front_entry)
   );

   pevc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(front_entry),
      .pop      (q_pop),
      .pop_data (q_data),
      .full     (q_full),
      .not_empty(q_not_empty)
   );

   pevc_back #(
      .TRIG_STAGES(TRIG_STAGES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .gains      (gains_ff),
      .q_not_empty(q_not_empty),
      .q_data     (q_data),
      .q_pop      (q_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (rsp_tdata)
   );

endmodule

// ===== hw/rtl/pevc_front.sv =====
// ---------------------------------------------------------------------------
// pevc_front
// Takes a pose word apart and forms position errors, heading error and the
// folded CORDIC start angle.
// ---------------------------------------------------------------------------
module pevc_front (
   input  logic [159:0]        pose,
   output pevc_pkg::entry_type entry
);

   logic signed [31:0] cur_x;
   logic signed [31:0] cur_y;
   logic [15:0]        cur_heading;
   logic signed [31:0] goal_x;
   logic signed [31:0] goal_y;
   logic [15:0]        goal_heading;
   logic               flip;

   // Field split, lowest field first.
   assign cur_x        = pose[31:0];
   assign cur_y        = pose[63:32];
   assign cur_heading  = pose[79:64];
   assign goal_x       = pose[111:80];
   assign goal_y       = pose[143:112];
   assign goal_heading = pose[159:144];

   // Headings in the left half plane are turned by half a turn.
   assign flip = cur_heading[15] ^ cur_heading[14];

   always_comb begin
      entry.err_x       = 33'(goal_x) - 33'(cur_x);
      entry.err_y       = 33'(goal_y) - 33'(cur_y);
      entry.err_heading = goal_heading - cur_heading;
      entry.angle       = $signed({cur_heading[15] ^ flip, cur_heading[15] ^ flip,
                                   cur_heading[14:0], 16'd0});
      entry.flip        = flip;
   end

endmodule

// ===== hw/rtl/pevc_queue.sv =====
// ---------------------------------------------------------------------------
// pevc_queue
// Short first-in first-out queue between the front and the back end.
// ---------------------------------------------------------------------------
module pevc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  pevc_pkg::entry_type push_data,
   input  logic                pop,
   output pevc_pkg::entry_type pop_data,
   output logic                full,
   output logic                not_empty
);

   localparam int PW = pevc_pkg::QUEUE_PTR_W;

   pevc_pkg::entry_type mem_ff [pevc_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff,  count_in;

   assign full      = (count_ff == (PW+1)'(pevc_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/pevc_cordic.sv =====
// ---------------------------------------------------------------------------
// pevc_cordic
// Pipelined rotation-mode CORDIC, one stage per iteration, giving cosine and
// sine of the heading in Q2.30 with the errors carried alongside.
// ---------------------------------------------------------------------------
module pevc_cordic #(
   parameter int TRIG_STAGES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  pevc_pkg::entry_type in_entry,
   output logic                out_valid,
   output logic signed [31:0]  cos_out,
   output logic signed [31:0]  sin_out,
   output pevc_pkg::entry_type out_entry
);

   localparam int N = TRIG_STAGES;

   logic signed [33:0]  x_ff [N];
   logic signed [33:0]  y_ff [N];
   logic signed [32:0]  z_ff [N];
   pevc_pkg::entry_type side_ff [N];
   logic [N-1:0]        vld_ff;

   logic signed [31:0]  cos_ff, sin_ff;
   pevc_pkg::entry_type out_side_ff;
   logic                out_vld_ff;

   // One iteration per stage.
   for (genvar i = 0; i < N; i++) begin : g_stage
      logic signed [33:0]  x_prev, y_prev, x_in, y_in, xs, ys;
      logic signed [32:0]  z_prev, z_in;
      pevc_pkg::entry_type side_prev;
      logic                vld_prev;

      if (i == 0) begin : g_first
         assign x_prev    = pevc_pkg::CORDIC_K;
         assign y_prev    = '0;
         assign z_prev    = in_entry.angle;
         assign side_prev = in_entry;
         assign vld_prev  = in_valid;
      end else begin : g_next
         assign x_prev    = x_ff[i-1];
         assign y_prev    = y_ff[i-1];
         assign z_prev    = z_ff[i-1];
         assign side_prev = side_ff[i-1];
         assign vld_prev  = vld_ff[i-1];
      end

      always_comb begin
         xs = x_prev >>> i;
         ys = y_prev >>> i;
         if (!z_prev[32]) begin
            x_in = x_prev - ys;
            y_in = y_prev + xs;
            z_in = z_prev - pevc_pkg::atan_turn(5'(i));
         end else begin
            x_in = x_prev + ys;
            y_in = y_prev - xs;
            z_in = z_prev + pevc_pkg::atan_turn(5'(i));
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (advance) begin
            vld_ff[i] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[i]    <= x_in;
            y_ff[i]    <= y_in;
            z_ff[i]    <= z_in;
            side_ff[i] <= side_prev;
         end
      end
   end

   // Undo the half-turn fold and narrow to Q2.30 in 32 bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= vld_ff[N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cos_ff      <= side_ff[N-1].flip ? 32'(-x_ff[N-1]) : 32'(x_ff[N-1]);
         sin_ff      <= side_ff[N-1].flip ? 32'(-y_ff[N-1]) : 32'(y_ff[N-1]);
         out_side_ff <= side_ff[N-1];
      end
   end

   assign out_valid = out_vld_ff;
   assign cos_out   = cos_ff;
   assign sin_out   = sin_ff;
   assign out_entry = out_side_ff;

endmodule

// ===== hw/rtl/pevc_back.sv =====
// ---------------------------------------------------------------------------
// pevc_back
// Back end: trigonometry, frame rotation, gain scaling and saturation, with
// the result word held in an output register.
// ---------------------------------------------------------------------------
module pevc_back #(
   parameter int TRIG_STAGES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  pevc_pkg::gains_type gains,
   input  logic                q_not_empty,
   input  pevc_pkg::entry_type q_data,
   output logic                q_pop,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [95:0]         out_data
);

   logic                advance;
   logic                c_valid;
   logic signed [31:0]  c_cos, c_sin;
   pevc_pkg::entry_type c_entry;

   logic               m1_vld_ff;
   logic signed [64:0] p_cx_ff, p_sy_ff, p_sx_ff, p_cy_ff;
   logic signed [32:0] hg_ff;

   logic               m2_vld_ff;
   logic signed [35:0] fwd_ff, lat_ff;
   logic signed [66:0] turn_p_ff;

   logic               m3_vld_ff;
   logic signed [52:0] gf_ff, gl_ff;
   logic signed [31:0] turn_ff;

   logic               out_vld_ff;
   logic [95:0]        out_data_ff;

   // The whole back end moves while the output register is free or taken.
   assign advance   = !out_vld_ff || out_ready;
   assign q_pop     = advance && q_not_empty;
   assign out_valid = out_vld_ff;
   assign out_data  = out_data_ff;

   pevc_cordic #(
      .TRIG_STAGES(TRIG_STAGES)
   ) u_cordic (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (q_not_empty),
      .in_entry (q_data),
      .out_valid(c_valid),
      .cos_out  (c_cos),
      .sin_out  (c_sin),
      .out_entry(c_entry)
   );

   // Valid chain of the arithmetic stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff  <= 1'b0;
         m2_vld_ff  <= 1'b0;
         m3_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         m1_vld_ff  <= c_valid;
         m2_vld_ff  <= m1_vld_ff;
         m3_vld_ff  <= m2_vld_ff;
         out_vld_ff <= m3_vld_ff;
      end
   end

   // Rotation products and heading error times gain.
   always_ff @(posedge clock) begin
      if (advance) begin
         p_cx_ff <= c_cos * c_entry.err_x;
         p_sy_ff <= c_sin * c_entry.err_y;
         p_sx_ff <= c_sin * c_entry.err_x;
         p_cy_ff <= c_cos * c_entry.err_y;
         hg_ff   <= c_entry.err_heading * $signed({1'b0, gains.gain_heading});
      end
   end

   // Robot-frame errors and the radian scaling of the heading term.
   always_ff @(posedge clock) begin
      if (advance) begin
         fwd_ff    <= 36'(p_cx_ff >>> 30) + 36'(p_sy_ff >>> 30);
         lat_ff    <= 36'((-p_sx_ff) >>> 30) + 36'(p_cy_ff >>> 30);
         turn_p_ff <= hg_ff * $signed({1'b0, pevc_pkg::TWO_PI_Q29});
      end
   end

   // Linear gains.
   always_ff @(posedge clock) begin
      if (advance) begin
         gf_ff   <= fwd_ff * $signed({1'b0, gains.gain_x});
         gl_ff   <= lat_ff * $signed({1'b0, gains.gain_y});
         turn_ff <= 32'(turn_p_ff >>> 37);
      end
   end

   // Saturation into the output register.
   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= {turn_ff,
                         pevc_pkg::sat32(45'(gl_ff >>> 8)),
                         pevc_pkg::sat32(45'(gf_ff >>> 8))};
      end
   end

endmodule

// ===== hw/rtl/pevc_checker.sv =====
// ---------------------------------------------------------------------------
// pevc_checker
// Port-level checks of the core, bound to the top level.
// ---------------------------------------------------------------------------
`include "pose_error_velocity_control_core_macros.svh"

module pevc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata,
   input logic        csr_ready
);

   // No word leaves straight after reset.
   `PEVC_ASSERT_NXT(a_idle_after_reset, clock, 1'b0, reset, !rsp_tvalid)
   // The queue is empty after reset, so input is taken at once.
   `PEVC_ASSERT_IMP(a_ready_after_reset, clock, reset, $past(reset), req_tready)
   // Gain writes are never held off.
   `PEVC_ASSERT_IMP(a_csr_ready, clock, reset, 1'b1, csr_ready)
   // A stalled result word holds.
   `PEVC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))

endmodule

bind pose_error_velocity_control_core pevc_checker u_pevc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .csr_ready (csr_ready)
);
